// ===== rtl/core/power_key_gesture_classifier_core_defines.svh =====
// Assertion macros for the power key gesture classifier core.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef POWER_KEY_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define POWER_KEY_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PKGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkgc check failed");
// Next-cycle implication, disabled during reset
`define PKGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkgc check failed");
`else
`define PKGC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PKGC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/pkgc_pkg.sv =====
// Shared types and constants for the power key gesture classifier.
// No dependencies; used by pkgc_step and the core top level.
package pkgc_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK         = 3'd0;
    localparam logic [2:0] CMD_PRESS        = 3'd1;
    localparam logic [2:0] CMD_RELEASE      = 3'd2;
    localparam logic [2:0] CMD_FORCE_SHORT  = 3'd3;
    localparam logic [2:0] CMD_FORCE_LONG   = 3'd4;
    localparam logic [2:0] CMD_FORCE_DOUBLE = 3'd5;

    // System state codes
    localparam logic [2:0] SYS_USER     = 3'd0;
    localparam logic [2:0] SYS_ACT_DEAD = 3'd1;
    localparam logic [2:0] SYS_SHUTDOWN = 3'd2;
    localparam logic [2:0] SYS_REBOOT   = 3'd3;

    // Gesture codes
    localparam logic [1:0] GEST_NONE   = 2'd0;
    localparam logic [1:0] GEST_SHORT  = 2'd1;
    localparam logic [1:0] GEST_DOUBLE = 2'd2;
    localparam logic [1:0] GEST_LONG   = 2'd3;

    // Long-press outcome codes
    localparam logic [2:0] OUT_NONE       = 3'd0;
    localparam logic [2:0] OUT_LONG_ACT   = 3'd1;
    localparam logic [2:0] OUT_SOFT_ON    = 3'd2;
    localparam logic [2:0] OUT_POWER_UP   = 3'd3;
    localparam logic [2:0] OUT_SHUTDOWN   = 3'd4;
    localparam logic [2:0] OUT_ALARM_IGN  = 3'd5;
    localparam logic [2:0] OUT_STOPPING   = 3'd6;

    // Action codes
    localparam logic [2:0] ACT_DISABLED = 3'd0;
    localparam logic [2:0] ACT_LOCK     = 3'd4;
    localparam logic [2:0] ACT_UNLOCK   = 3'd5;
    localparam logic [2:0] ACT_BOTH     = 3'd6;
    localparam logic [2:0] ACT_SIGNAL   = 3'd7;

    // Register indexes
    localparam logic [2:0] REG_MEDIUM_DELAY   = 3'd0;
    localparam logic [2:0] REG_LONG_DELAY     = 3'd1;
    localparam logic [2:0] REG_DOUBLE_DELAY   = 3'd2;
    localparam logic [2:0] REG_SHORT_ACTION   = 3'd3;
    localparam logic [2:0] REG_LONG_ACTION    = 3'd4;
    localparam logic [2:0] REG_DOUBLE_ACTION  = 3'd5;
    localparam logic [2:0] REG_OVR_COUNT      = 3'd6;
    localparam logic [2:0] REG_OVR_GAP        = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_MEDIUM_DELAY  = 16'd1000;
    localparam logic [15:0] RST_LONG_DELAY    = 16'd1500;
    localparam logic [15:0] RST_DOUBLE_DELAY  = 16'd500;
    localparam logic [2:0]  RST_SHORT_ACTION  = 3'd4;
    localparam logic [2:0]  RST_LONG_ACTION   = 3'd2;
    localparam logic [2:0]  RST_DOUBLE_ACTION = 3'd5;
    localparam logic [7:0]  RST_OVR_COUNT     = 8'd3;
    localparam logic [15:0] RST_OVR_GAP       = 16'd333;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] sys_mode;
        logic       touch_lock_on;
        logic       soft_off_on;
        logic       proximity_covered;
        logic       alarm_showing;
    } in_item_t;

    typedef struct packed {
        logic [1:0] gesture;
        logic [2:0] chosen_action;
        logic [2:0] long_outcome;
        logic       override_fire;
        logic       timers_busy;
    } out_item_t;

    typedef struct packed {
        logic [15:0] medium_delay_ms;
        logic [15:0] long_delay_ms;
        logic [15:0] double_delay_ms;
        logic [2:0]  short_action;
        logic [2:0]  long_action;
        logic [2:0]  double_action;
        logic [7:0]  override_press_count;
        logic [15:0] override_gap_ms;
    } cfg_regs_t;

    typedef struct packed {
        logic [15:0] long_countdown;
        logic        long_running;
        logic [15:0] double_countdown;
        logic        double_running;
        logic [7:0]  override_count;
        logic [15:0] since_last_release;
        logic        last_release_valid;
    } gest_state_t;

endpackage

// ===== rtl/core/pkgc_step.sv =====
// Per-event update of the gesture classifier: next timer state and result.
// Pure combinational; depends on pkgc_pkg.
module pkgc_step (
    input  pkgc_pkg::cfg_regs_t   cfg,
    input  pkgc_pkg::gest_state_t cur,
    input  pkgc_pkg::in_item_t    item,
    output pkgc_pkg::gest_state_t nxt,
    output pkgc_pkg::out_item_t   result
);
    import pkgc_pkg::*;

    logic [2:0]  long_outcome;
    logic [15:0] dbl_dec;
    logic        dbl_expired;
    logic [15:0] long_dec;
    logic        long_expired;
    logic        window_ok;
    logic [15:0] press_delay;
    logic        ovr_enabled;
    logic [7:0]  ovr_base;
    logic [7:0]  ovr_inc;
    logic        ovr_hit;
    logic [1:0]  gesture;
    logic [2:0]  action;
    logic [2:0]  outcome;
    logic        fire;

    // Outcome of a long press from the status bits
    always_comb
    begin
        priority if (item.alarm_showing)
            long_outcome = OUT_ALARM_IGN;
        else if (item.sys_mode == SYS_SHUTDOWN || item.sys_mode == SYS_REBOOT)
            long_outcome = OUT_STOPPING;
        else if (item.sys_mode == SYS_ACT_DEAD)
            long_outcome = OUT_POWER_UP;
        else if (item.sys_mode == SYS_USER)
            long_outcome = item.soft_off_on ? OUT_SOFT_ON : OUT_LONG_ACT;
        else
            long_outcome = OUT_SHUTDOWN;
    end

    // Countdown steps: expire once the count is one or zero
    assign dbl_expired  = (cur.double_countdown <= 16'd1);
    assign dbl_dec      = dbl_expired ? 16'd0 : cur.double_countdown - 16'd1;
    assign long_expired = (cur.long_countdown <= 16'd1);
    assign long_dec     = long_expired ? 16'd0 : cur.long_countdown - 16'd1;

    // May a release open the double-press window
    assign window_ok = (cfg.double_action != ACT_DISABLED)
        && ((cfg.double_action == ACT_SIGNAL)
            || (item.touch_lock_on
                ? (cfg.double_action == ACT_UNLOCK || cfg.double_action == ACT_BOTH)
                : !(cfg.short_action == ACT_LOCK || cfg.short_action == ACT_BOTH)));

    assign press_delay = (item.sys_mode == SYS_ACT_DEAD || item.soft_off_on)
        ? cfg.medium_delay_ms : cfg.long_delay_ms;

    // Proximity override release counting
    assign ovr_enabled = (cfg.override_press_count != 8'd0)
        && (cfg.override_gap_ms != 16'd0) && item.proximity_covered;
    assign ovr_base = (!cur.last_release_valid || cur.since_last_release > cfg.override_gap_ms)
        ? 8'd0 : cur.override_count;
    assign ovr_inc  = ovr_base + 8'd1;
    assign ovr_hit  = (ovr_inc == cfg.override_press_count);

    // Event dispatch
    always_comb
    begin
        nxt     = cur;
        gesture = GEST_NONE;
        action  = ACT_DISABLED;
        outcome = OUT_NONE;
        fire    = 1'b0;
        unique case (item.command)
            CMD_TICK:
            begin
                if (cur.last_release_valid && cur.since_last_release != ELAPSED_MAX)
                    nxt.since_last_release = cur.since_last_release + 16'd1;
                if (cur.double_running)
                begin
                    nxt.double_countdown = dbl_dec;
                    if (dbl_expired)
                    begin
                        nxt.double_running = 1'b0;
                        if (item.sys_mode == SYS_USER)
                        begin
                            gesture = GEST_SHORT;
                            action  = cfg.short_action;
                        end
                    end
                end
                // long expiry wins if both end together
                if (cur.long_running)
                begin
                    nxt.long_countdown = long_dec;
                    if (long_expired)
                    begin
                        nxt.long_running = 1'b0;
                        gesture = GEST_LONG;
                        action  = ACT_DISABLED;
                        outcome = long_outcome;
                    end
                end
            end
            CMD_PRESS:
            begin
                if (cur.double_running)
                begin
                    nxt.long_running   = 1'b0;
                    nxt.double_running = 1'b0;
                    gesture = GEST_DOUBLE;
                    action  = cfg.double_action;
                end
                else
                begin
                    nxt.long_countdown = press_delay;
                    nxt.long_running   = 1'b1;
                end
            end
            CMD_RELEASE:
            begin
                if (!ovr_enabled)
                begin
                    nxt.last_release_valid = 1'b0;
                    nxt.override_count     = 8'd0;
                end
                else
                begin
                    nxt.since_last_release = 16'd0;
                    nxt.last_release_valid = !ovr_hit;
                    nxt.override_count     = ovr_hit ? 8'd0 : ovr_inc;
                    fire                   = ovr_hit;
                end
                if (cur.long_running)
                begin
                    nxt.long_running = 1'b0;
                    if (cur.double_running)
                    begin
                        nxt.double_running = 1'b0;
                        gesture = GEST_DOUBLE;
                        action  = cfg.double_action;
                    end
                    else if (window_ok)
                    begin
                        nxt.double_countdown = cfg.double_delay_ms;
                        nxt.double_running   = 1'b1;
                    end
                    else
                    begin
                        gesture = GEST_SHORT;
                        action  = cfg.short_action;
                    end
                end
            end
            CMD_FORCE_SHORT:
            begin
                nxt.long_running   = 1'b0;
                nxt.double_running = 1'b0;
                gesture = GEST_SHORT;
                action  = cfg.short_action;
            end
            CMD_FORCE_LONG:
            begin
                nxt.long_running   = 1'b0;
                nxt.double_running = 1'b0;
                gesture = GEST_LONG;
                outcome = long_outcome;
            end
            CMD_FORCE_DOUBLE:
            begin
                nxt.long_running   = 1'b0;
                nxt.double_running = 1'b0;
                gesture = GEST_DOUBLE;
                action  = cfg.double_action;
            end
            default:
            begin
                // unused command codes leave everything alone
                nxt = cur;
            end
        endcase
    end

    assign result.gesture       = gesture;
    assign result.chosen_action = action;
    assign result.long_outcome  = outcome;
    assign result.override_fire = fire;
    assign result.timers_busy   = nxt.long_running | nxt.double_running;

endmodule

// ===== rtl/core/power_key_gesture_classifier_core.sv =====
// Top level of the power key gesture classifier: event register, timer
// state, result register and configuration. Depends on pkgc_pkg, pkgc_step
// and power_key_gesture_classifier_core_defines.svh.
`include "power_key_gesture_classifier_core_defines.svh"

// Classifies power key events (millisecond ticks, presses, releases and
// software triggers) into short, double and long gestures and fires the
// proximity override. Every event gives exactly one result. One event is
// taken per clock cycle while the result register is not stalled; the whole
// update is done in a single pass between the event register and the result
// register, so each result is registered straight from its event by pkgc_step.
// A stalled result holds the pipe but the event register still takes one
// more event. Configuration writes are always ready and take effect at once;
// write them only while no event is in flight. Tick events drive every
// timer, so the delays count ticks, not clock cycles.
module power_key_gesture_classifier_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ev_valid,
    output logic                ev_ready,
    input  pkgc_pkg::in_item_t  ev_item,
    output logic                res_valid,
    input  logic                res_ready,
    output pkgc_pkg::out_item_t res_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import pkgc_pkg::*;

    logic        ev_vld_reg;
    logic        ev_vld_next;
    in_item_t    ev_reg;
    logic        res_vld_reg;
    logic        res_vld_next;
    out_item_t   res_reg;
    cfg_regs_t   cfg_reg;
    gest_state_t st_reg;
    gest_state_t st_next;
    out_item_t   step_res;
    logic        advance;
    logic        ev_xfer;

    // Pipe control
    assign advance      = ev_vld_reg && (!res_vld_reg || res_ready);
    assign ev_ready     = !ev_vld_reg || advance;
    assign ev_xfer      = ev_valid && ev_ready;
    assign ev_vld_next  = ev_xfer || (ev_vld_reg && !advance);
    assign res_vld_next = advance || (res_vld_reg && !res_ready);
    assign cfg_ready    = 1'b1;

    // Event update
    pkgc_step u_step (
        .cfg    (cfg_reg),
        .cur    (st_reg),
        .item   (ev_reg),
        .nxt    (st_next),
        .result (step_res)
    );

    // Control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            st_reg      <= '0;
        end
        else
        begin
            ev_vld_reg  <= ev_vld_next;
            res_vld_reg <= res_vld_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ev_xfer)
            ev_reg <= ev_item;
        if (advance)
            res_reg <= step_res;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.medium_delay_ms      <= RST_MEDIUM_DELAY;
            cfg_reg.long_delay_ms        <= RST_LONG_DELAY;
            cfg_reg.double_delay_ms      <= RST_DOUBLE_DELAY;
            cfg_reg.short_action         <= RST_SHORT_ACTION;
            cfg_reg.long_action          <= RST_LONG_ACTION;
            cfg_reg.double_action        <= RST_DOUBLE_ACTION;
            cfg_reg.override_press_count <= RST_OVR_COUNT;
            cfg_reg.override_gap_ms      <= RST_OVR_GAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MEDIUM_DELAY:  cfg_reg.medium_delay_ms      <= cfg_data;
                REG_LONG_DELAY:    cfg_reg.long_delay_ms        <= cfg_data;
                REG_DOUBLE_DELAY:  cfg_reg.double_delay_ms      <= cfg_data;
                REG_SHORT_ACTION:  cfg_reg.short_action         <= cfg_data[2:0];
                REG_LONG_ACTION:   cfg_reg.long_action          <= cfg_data[2:0];
                REG_DOUBLE_ACTION: cfg_reg.double_action        <= cfg_data[2:0];
                REG_OVR_COUNT:     cfg_reg.override_press_count <= cfg_data[7:0];
                REG_OVR_GAP:       cfg_reg.override_gap_ms      <= cfg_data;
            endcase
        end
    end

    assign res_valid = res_vld_reg;
    assign res_item  = res_reg;

    // The long-press action register feeds no result: long gestures
    // report an outcome only.

    // Checks
    `PKGC_ASSERT_IMP(a_outcome_only_long, clk, rst_n, res_valid,
        ((res_item.gesture == GEST_LONG) == (res_item.long_outcome != OUT_NONE)))
    `PKGC_ASSERT_IMP(a_action_only_short_double, clk, rst_n,
        res_valid && (res_item.gesture == GEST_NONE || res_item.gesture == GEST_LONG),
        res_item.chosen_action == ACT_DISABLED)
    `PKGC_ASSERT_NXT(a_busy_tracks_state, clk, rst_n, advance,
        res_item.timers_busy == (st_reg.long_running || st_reg.double_running))
    `PKGC_ASSERT_NXT(a_fire_clears_count, clk, rst_n, advance && step_res.override_fire,
        st_reg.override_count == 8'd0 && !st_reg.last_release_valid)

endmodule
